/* design/pale_pkg.sv */
// ---------------------------------------------------------------------------
// pale_pkg
// Shared types and codes for the positional array list engine: command and
// status codes, controller states and the controller/datapath interfaces.
// ---------------------------------------------------------------------------
package pale_pkg;

    // list command codes, as carried in the input tuser
    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_READ   = 3'd4
    } command_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_DRAIN,
        S_INS_WRITE,
        S_SCAN,
        S_RD_ISSUE,
        S_RD_TAKE,
        S_FINISH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    capture;
        logic    clear_count;
        logic    inc_count;
        logic    dec_count;
        logic    ptr_load;
        logic    shift_rd;
        logic    scan_rd;
        logic    write_op;
        logic    status_load;
        status_t status_val;
        logic    found_load;
        logic    rval_load;
        logic    out_load;
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic [2:0] command;
        logic       full;
        logic       ins_ok;
        logic       del_ok;
        logic       rd_ok;
        logic       ins_tail;
        logic       del_tail;
        logic       count_zero;
        logic       shift_last;
        logic       match;
        logic       scan_miss;
    } dp_stat_t;

endpackage

/* design/pale_dpath.sv */
// ---------------------------------------------------------------------------
// pale_dpath
// Datapath of the list engine: element memory, count, pointers, compare
// logic, working result and the output register.
// ---------------------------------------------------------------------------
module pale_dpath #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pale_pkg::ctl_t      ctl,
    input  logic [2:0]          in_command,
    input  logic [5:0]          in_position,
    input  logic signed [31:0]  in_operand,
    output pale_pkg::dp_stat_t  st,
    output logic [1:0]          status,
    output logic [4:0]          found_index,
    output logic signed [31:0]  read_value,
    output logic [5:0]          element_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 6) ? CW : 6) + 1;

    // captured command
    logic [2:0]            command_reg;
    logic [5:0]            position_reg;
    logic [DATA_WIDTH-1:0] operand_reg;

    // list state and sweep control
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]         cmp_addr_reg, cmp_addr_next;

    // element memory with registered read
    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;

    // working result and output register
    pale_pkg::status_t     res_status_reg;
    logic [4:0]            res_found_reg;
    logic [31:0]           res_rval_reg;
    pale_pkg::status_t     out_status_reg;
    logic [4:0]            out_found_reg;
    logic [31:0]           out_rval_reg;
    logic [5:0]            out_count_reg;

    logic [PW-1:0]         pos_w, cnt_w, ptr_w;
    logic                  is_insert;
    logic                  scan_issue;
    logic                  match;
    logic signed [DATA_WIDTH-1:0] rdata_s;

    assign pos_w     = PW'(position_reg);
    assign cnt_w     = PW'(count_reg);
    assign ptr_w     = PW'(ptr_reg);
    assign is_insert = (command_reg == pale_pkg::CMD_INSERT);
    assign scan_issue = ctl.scan_rd && (ptr_reg < count_reg);
    assign match     = cmp_valid_reg && (rdata_reg == operand_reg);
    assign rdata_s   = rdata_reg;

    // status towards the controller
    always_comb
    begin
        st.command    = command_reg;
        st.full       = (count_reg == CW'(CAPACITY));
        st.ins_ok     = (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
        st.del_ok     = (pos_w != '0) && (pos_w <= cnt_w);
        st.rd_ok      = (pos_w < cnt_w);
        st.ins_tail   = (pos_w == cnt_w + PW'(1));
        st.del_tail   = (pos_w == cnt_w);
        st.count_zero = (count_reg == '0);
        st.shift_last = is_insert ? (ptr_w + PW'(1) == pos_w)
                                  : (ptr_w + PW'(1) == cnt_w);
        st.match      = match;
        st.scan_miss  = cmp_valid_reg && !match && (cmp_addr_reg + CW'(1) == count_reg);
    end

    // next values of count, pointer and in-flight markers
    always_comb
    begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        cmp_valid_next  = 1'b0;
        cmp_addr_next   = cmp_addr_reg;

        if (ctl.clear_count)
            count_next = '0;
        else if (ctl.inc_count)
            count_next = count_reg + CW'(1);
        else if (ctl.dec_count)
            count_next = count_reg - CW'(1);

        if (ctl.ptr_load)
        begin
            case (pale_pkg::command_t'(command_reg))
                pale_pkg::CMD_INSERT: ptr_next = count_reg - CW'(1);
                pale_pkg::CMD_DELETE: ptr_next = CW'(pos_w);
                pale_pkg::CMD_READ:   ptr_next = CW'(pos_w);
                default:              ptr_next = '0;
            endcase
        end
        else if (ctl.shift_rd)
        begin
            pend_valid_next = 1'b1;
            if (is_insert)
            begin
                pend_addr_next = AW'(ptr_reg + CW'(1));
                ptr_next       = ptr_reg - CW'(1);
            end
            else
            begin
                pend_addr_next = AW'(ptr_reg - CW'(1));
                ptr_next       = ptr_reg + CW'(1);
            end
        end
        else if (scan_issue)
        begin
            cmp_valid_next = 1'b1;
            cmp_addr_next  = ptr_reg;
            ptr_next       = ptr_reg + CW'(1);
        end
    end

    // memory write port: shifted element or inserted value
    always_comb
    begin
        mem_we    = ctl.write_op || pend_valid_reg;
        mem_waddr = ctl.write_op ? AW'(pos_w - PW'(1)) : pend_addr_reg;
        mem_wdata = ctl.write_op ? operand_reg : rdata_reg;
    end

    // element memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[ptr_reg[AW-1:0]];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            cmp_valid_reg  <= cmp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        cmp_addr_reg  <= cmp_addr_next;

        if (ctl.capture)
        begin
            command_reg    <= in_command;
            position_reg   <= in_position;
            operand_reg    <= DATA_WIDTH'(in_operand);
            res_status_reg <= pale_pkg::ST_OK;
            res_found_reg  <= '0;
            res_rval_reg   <= '0;
        end
        else
        begin
            if (ctl.status_load)
                res_status_reg <= ctl.status_val;
            if (ctl.found_load)
                res_found_reg <= 5'(cmp_addr_reg);
            if (ctl.rval_load)
                res_rval_reg <= 32'(rdata_s);
        end

        if (ctl.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_rval_reg   <= res_rval_reg;
            out_count_reg  <= 6'(count_reg);
        end
    end

    assign status        = out_status_reg;
    assign found_index   = out_found_reg;
    assign read_value    = out_rval_reg;
    assign element_count = out_count_reg;

endmodule

/* design/pale_ctrl.sv */
// ---------------------------------------------------------------------------
// pale_ctrl
// Controller of the list engine: sequences each command over the datapath
// and owns the input ready and the output valid.
// ---------------------------------------------------------------------------
module pale_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  pale_pkg::dp_stat_t st,
    output pale_pkg::ctl_t     ctl
);

    pale_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == pale_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pale_pkg::S_IDLE:
                if (s_tvalid)
                    state_next = pale_pkg::S_DECIDE;
            pale_pkg::S_DECIDE:
            begin
                case (pale_pkg::command_t'(st.command))
                    pale_pkg::CMD_INSERT:
                        if (st.full || !st.ins_ok)
                            state_next = pale_pkg::S_FINISH;
                        else if (st.ins_tail)
                            state_next = pale_pkg::S_INS_WRITE;
                        else
                            state_next = pale_pkg::S_SHIFT;
                    pale_pkg::CMD_DELETE:
                        if (!st.del_ok || st.del_tail)
                            state_next = pale_pkg::S_FINISH;
                        else
                            state_next = pale_pkg::S_SHIFT;
                    pale_pkg::CMD_SEARCH:
                        state_next = st.count_zero ? pale_pkg::S_FINISH : pale_pkg::S_SCAN;
                    pale_pkg::CMD_READ:
                        state_next = st.rd_ok ? pale_pkg::S_RD_ISSUE : pale_pkg::S_FINISH;
                    default:
                        state_next = pale_pkg::S_FINISH;
                endcase
            end
            pale_pkg::S_SHIFT:
                if (st.shift_last)
                    state_next = pale_pkg::S_DRAIN;
            pale_pkg::S_DRAIN:
                if (st.command == pale_pkg::CMD_INSERT)
                    state_next = pale_pkg::S_INS_WRITE;
                else
                    state_next = pale_pkg::S_FINISH;
            pale_pkg::S_INS_WRITE:
                state_next = pale_pkg::S_FINISH;
            pale_pkg::S_SCAN:
                if (st.match || st.scan_miss)
                    state_next = pale_pkg::S_FINISH;
            pale_pkg::S_RD_ISSUE:
                state_next = pale_pkg::S_RD_TAKE;
            pale_pkg::S_RD_TAKE:
                state_next = pale_pkg::S_FINISH;
            pale_pkg::S_FINISH:
                if (out_free)
                    state_next = pale_pkg::S_IDLE;
            default:
                state_next = pale_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        ctl = '0;
        ctl.status_val = pale_pkg::ST_OK;
        case (state_reg)
            pale_pkg::S_IDLE:
                ctl.capture = s_tvalid;
            pale_pkg::S_DECIDE:
            begin
                case (pale_pkg::command_t'(st.command))
                    pale_pkg::CMD_CLEAR:
                        ctl.clear_count = 1'b1;
                    pale_pkg::CMD_INSERT:
                        if (st.full)
                        begin
                            ctl.status_load = 1'b1;
                            ctl.status_val  = pale_pkg::ST_FULL;
                        end
                        else if (!st.ins_ok)
                        begin
                            ctl.status_load = 1'b1;
                            ctl.status_val  = pale_pkg::ST_BADPOS;
                        end
                        else if (!st.ins_tail)
                            ctl.ptr_load = 1'b1;
                    pale_pkg::CMD_DELETE:
                        if (!st.del_ok)
                        begin
                            ctl.status_load = 1'b1;
                            ctl.status_val  = pale_pkg::ST_BADPOS;
                        end
                        else if (st.del_tail)
                            ctl.dec_count = 1'b1;
                        else
                            ctl.ptr_load = 1'b1;
                    pale_pkg::CMD_SEARCH:
                        if (st.count_zero)
                        begin
                            ctl.status_load = 1'b1;
                            ctl.status_val  = pale_pkg::ST_NOTFOUND;
                        end
                        else
                            ctl.ptr_load = 1'b1;
                    pale_pkg::CMD_READ:
                        if (!st.rd_ok)
                        begin
                            ctl.status_load = 1'b1;
                            ctl.status_val  = pale_pkg::ST_BADPOS;
                        end
                        else
                            ctl.ptr_load = 1'b1;
                    default:
                        ctl.status_load = 1'b0;
                endcase
            end
            pale_pkg::S_SHIFT:
                ctl.shift_rd = 1'b1;
            pale_pkg::S_DRAIN:
                ctl.dec_count = (st.command == pale_pkg::CMD_DELETE);
            pale_pkg::S_INS_WRITE:
            begin
                ctl.write_op  = 1'b1;
                ctl.inc_count = 1'b1;
            end
            pale_pkg::S_SCAN:
            begin
                ctl.scan_rd = 1'b1;
                if (st.match)
                    ctl.found_load = 1'b1;
                else if (st.scan_miss)
                begin
                    ctl.status_load = 1'b1;
                    ctl.status_val  = pale_pkg::ST_NOTFOUND;
                end
            end
            pale_pkg::S_RD_TAKE:
                ctl.rval_load = 1'b1;
            pale_pkg::S_FINISH:
                ctl.out_load = out_free;
            default:
                ctl.capture = 1'b0;
        endcase
    end

    // output valid: set on load, dropped once the transfer completes
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (ctl.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pale_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

/* design/positional_array_list_engine.sv */
// ---------------------------------------------------------------------------
// positional_array_list_engine
// Ordered list of signed words with clear, insert, delete, search and read by
// position; one result transfer for every command transfer.
// ---------------------------------------------------------------------------
// Usage
//   Commands enter on the s_ stream: tuser carries the command code, tdata
//   the position and the operand. Each command yields one result on the m_
//   stream: tuser the status, tdata the found index, read value and count.
//   Commands are worked one at a time; the element memory has one read and
//   one write port and moves one element per cycle. Clear, failed, ignored
//   and tail-delete commands end in the decide state; a tail insert adds one
//   write, a read issues and takes one memory read, a search scans up to
//   count elements, and insert and delete shift the elements behind the
//   position, count being the elements held. The result can transfer from
//   the edge after its load, and the next command is accepted from that edge.
//   A new command is taken while the previous result still waits in the
//   output register; if the receiver stalls, the engine finishes the new
//   command and holds it until the output register drains.
//   Reset empties the list and drops any pending result; the memory itself
//   is not cleared, only entries below the count are ever read.
// ---------------------------------------------------------------------------
module positional_array_list_engine #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[5:0], operand_value[37:6], zero pad
    input  logic [2:0]  s_tuser,   // command[2:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // found_index[4:0], read_value[36:5],
                                   // element_count[42:37], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    pale_pkg::ctl_t     ctl;
    pale_pkg::dp_stat_t st;
    logic [1:0]         status;
    logic [4:0]         found_index;
    logic signed [31:0] read_value;
    logic [5:0]         element_count;

    // controller
    pale_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .ctl      (ctl)
    );

    // datapath
    pale_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .in_command    (s_tuser),
        .in_position   (s_tdata[5:0]),
        .in_operand    (s_tdata[37:6]),
        .st            (st),
        .status        (status),
        .found_index   (found_index),
        .read_value    (read_value),
        .element_count (element_count)
    );

    // result packing
    assign m_tdata = {5'd0, element_count, read_value, found_index};
    assign m_tuser = status;

endmodule
